// ===== sv/assert_macros.svh =====
// Assertion helpers for the receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst, ante, cons)
`define CHK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/ymr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ymr_pkg;
   localparam int MaxSizeDigits = 16;

   localparam logic [7:0] C_SOH = 8'h01;
   localparam logic [7:0] C_STX = 8'h02;
   localparam logic [7:0] C_EOT = 8'h04;
   localparam logic [7:0] C_ACK = 8'h06;
   localparam logic [7:0] C_NAK = 8'h15;
   localparam logic [7:0] C_CAN = 8'h18;
   localparam logic [7:0] C_CRC = 8'h43;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_REPLY   = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   localparam logic [0:0] REG_TIMEOUT = 1'b0;
   localparam logic [0:0] REG_MAXERR  = 1'b1;

   typedef enum logic [1:0] {
      FR_HEADER = 2'd0,
      FR_CANCEL = 2'd1,
      FR_BODY   = 2'd2
   } frame_type;

   typedef enum logic [1:0] {
      SP_NAME  = 2'd0,
      SP_DIGIT = 2'd1,
      SP_DONE  = 2'd2
   } parse_type;

   typedef enum logic [1:0] {
      SS_RECV  = 2'd0,
      SS_DONE  = 2'd1,
      SS_ABORT = 2'd2
   } sess_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       keep;
      logic       commit;
   } res_type;

   // Results of one item, as a small list with a count.
   typedef struct packed {
      logic [2:0]  count;
      res_type [3:0] res;
      logic [31:0] size;
      logic [1:0]  status;
   } bundle_type;

   // CRC-16/XMODEM update by one byte.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction
endpackage
`default_nettype wire

// ===== sv/ymr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ymr_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] in_byte;
   modport source (output valid, func, in_byte, input ready);
   modport sink (input valid, func, in_byte, output ready);
endinterface

interface ymr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  out_byte;
   logic        keep_byte;
   logic        commit;
   logic [31:0] size_bytes;
   logic [1:0]  session_status;
   logic        last;
   modport source (output valid, out_kind, out_byte, keep_byte, commit, size_bytes,
                   session_status, last, input ready);
   modport sink (input valid, out_kind, out_byte, keep_byte, commit, size_bytes,
                 session_status, last, output ready);
endinterface
`default_nettype wire

// ===== sv/ymodem_receiver.sv =====
// Output: an item's first result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle when it yields no result; otherwise the next item
// waits until the last of its results (up to three) drains, as rsp.ready allows.
// Reset: synchronous, active high; returns the protocol state and registers
// to their defaults (timeout 1000 ticks, error limit 5).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ymodem_receiver import ymr_pkg::*; #(
   parameter int MAX_SIZE_DIGITS = MaxSizeDigits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ymr_req_if.sink          req,
   ymr_rsp_if.source        rsp,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   logic [15:0] timeout_ff;
   logic [7:0]  maxerr_ff;
   logic        empty;
   logic        last_taken;
   logic        accept;
   bundle_type  bundle;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 16'd1000;
         maxerr_ff  <= 8'd5;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TIMEOUT: timeout_ff <= csr_wdata;
            REG_MAXERR:  maxerr_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // A new item enters when the result register is empty or draining its last.
   assign last_taken = rsp.valid && rsp.ready && rsp.last;
   assign req.ready  = !reset && (empty || last_taken);
   assign accept     = req.valid && req.ready;

   ymr_core #(.MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)) u_core (
      .clock, .reset, .step(accept), .func(req.func), .in_byte(req.in_byte),
      .timeout_ticks(timeout_ff), .err_limit(maxerr_ff), .bundle
   );

   ymr_outq u_outq (
      .clock, .reset, .load(accept), .bundle_in(bundle), .empty, .rsp
   );

   `CHK_IMPL(a_no_accept_busy, clock, reset, req.ready && rsp.valid, rsp.last && rsp.ready)
   `CHK_NEXT(a_load_valid, clock, reset, accept && bundle.count != 3'd0, rsp.valid)
   `CHK_IMPL(a_count_max, clock, reset, accept, bundle.count <= 3'd4)
endmodule
`default_nettype wire

// ===== sv/ymr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ymr_core import ymr_pkg::*; #(
   parameter int MAX_SIZE_DIGITS = MaxSizeDigits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        func,
   input  wire logic [7:0]  in_byte,
   input  wire logic [15:0] timeout_ticks,
   input  wire logic [7:0]  err_limit,
   output bundle_type       bundle
);
   localparam int DW = $clog2(MAX_SIZE_DIGITS + 1);

   frame_type   frame_ff, frame_in;
   logic [10:0] idx_ff, idx_in;
   logic        long_ff, long_in;
   logic [7:0]  seq_ff, seq_in, seqc_ff, seqc_in;
   logic [15:0] crc_ff, crc_in;
   logic        headnz_ff, headnz_in;
   parse_type   parse_ff, parse_in;
   logic [DW-1:0] digits_ff, digits_in;
   logic [31:0] accum_ff, accum_in;
   logic [7:0]  expseq_ff, expseq_in;
   logic        gotany_ff, gotany_in;
   logic [7:0]  errcnt_ff, errcnt_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] size_ff, size_in;
   logic [15:0] idle_ff, idle_in;
   sess_type    sess_ff, sess_in;

   // Registers; all state is control-like and reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FR_HEADER; idx_ff <= '0; long_ff <= 1'b0; seq_ff <= '0;
         seqc_ff <= '0; crc_ff <= '0; headnz_ff <= 1'b0; parse_ff <= SP_NAME;
         digits_ff <= '0; accum_ff <= '0; expseq_ff <= '0; gotany_ff <= 1'b0;
         errcnt_ff <= '0; remain_ff <= '0; size_ff <= '0; idle_ff <= '0;
         sess_ff <= SS_RECV;
      end else if (step) begin
         frame_ff <= frame_in; idx_ff <= idx_in; long_ff <= long_in; seq_ff <= seq_in;
         seqc_ff <= seqc_in; crc_ff <= crc_in; headnz_ff <= headnz_in;
         parse_ff <= parse_in; digits_ff <= digits_in; accum_ff <= accum_in;
         expseq_ff <= expseq_in; gotany_ff <= gotany_in; errcnt_ff <= errcnt_in;
         remain_ff <= remain_in; size_ff <= size_in; idle_ff <= idle_in;
         sess_ff <= sess_in;
      end
   end

   logic [2:0]    n;
   res_type [3:0] r;
   logic [10:0]   psize;
   logic [10:0]   p;
   logic [8:0]    errinc;
   logic [31:0]   dec;
   logic          keep;

   // Next state and result list for one item.
   always_comb begin
      frame_in = frame_ff; idx_in = idx_ff; long_in = long_ff; seq_in = seq_ff;
      seqc_in = seqc_ff; crc_in = crc_ff; headnz_in = headnz_ff; parse_in = parse_ff;
      digits_in = digits_ff; accum_in = accum_ff; expseq_in = expseq_ff;
      gotany_in = gotany_ff; errcnt_in = errcnt_ff; remain_in = remain_ff;
      size_in = size_ff; idle_in = idle_ff; sess_in = sess_ff;
      n = '0; r = '0;
      psize = long_ff ? 11'd1024 : 11'd128;
      p = idx_ff - 11'd2;
      errinc = {1'b0, errcnt_ff} + 9'd1;
      dec = (remain_ff < {21'd0, psize}) ? remain_ff : {21'd0, psize};
      keep = gotany_ff && (seq_ff == expseq_ff) && ({21'd0, p} < remain_ff);
      if (sess_ff == SS_RECV) begin
         if (func) begin
            if ({1'b0, idle_ff} + 17'd1 >= {1'b0, timeout_ticks}) begin
               idle_in = '0;
               frame_in = FR_HEADER;
               if (frame_ff == FR_CANCEL) begin
                  r[0] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
                  r[1] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
                  n = 3'd2; sess_in = SS_ABORT;
               end else begin
                  if (frame_ff == FR_BODY) begin
                     r[0] = '{KIND_VERDICT, 8'h00, 1'b0, 1'b0};
                     n = 3'd1;
                  end
                  if (gotany_ff) errcnt_in = errinc[7:0];
                  if (gotany_ff && errinc[7:0] >= err_limit) begin
                     r[n[1:0]] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
                     r[n[1:0] + 2'd1] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
                     n = n + 3'd2; sess_in = SS_ABORT;
                  end else begin
                     r[n[1:0]] = '{KIND_REPLY, C_CRC, 1'b0, 1'b0};
                     n = n + 3'd1;
                  end
               end
            end else begin
               idle_in = idle_ff + 16'd1;
            end
         end else begin
            idle_in = '0;
            if (frame_ff == FR_BODY) begin
               idx_in = idx_ff + 11'd1;
               if (idx_ff == 11'd0) seq_in = in_byte;
               else if (idx_ff == 11'd1) seqc_in = in_byte;
               else begin
                  crc_in = crc_byte(crc_ff, in_byte);
                  if (idx_ff < psize + 11'd2) begin
                     if (p < 11'd4 && in_byte != 8'h00) headnz_in = 1'b1;
                     if (parse_ff == SP_NAME) begin
                        if (in_byte == 8'h00) parse_in = SP_DIGIT;
                     end else if (parse_ff == SP_DIGIT) begin
                        if (in_byte >= 8'h30 && in_byte <= 8'h39 &&
                            digits_ff < DW'(MAX_SIZE_DIGITS)) begin
                           accum_in = (accum_ff << 3) + (accum_ff << 1)
                                      + {28'd0, in_byte[3:0]};
                           digits_in = digits_ff + DW'(1);
                           if (digits_in >= DW'(MAX_SIZE_DIGITS)) parse_in = SP_DONE;
                        end else begin
                           parse_in = SP_DONE;
                        end
                     end
                     r[0] = '{KIND_DATA, in_byte, keep, 1'b0};
                     n = 3'd1;
                  end
               end
               // End of packet: verdict and reply.
               if (idx_ff >= psize + 11'd3) begin
                  frame_in = FR_HEADER;
                  if (seq_ff != ~seqc_ff || crc_in != 16'h0000) begin
                     r[0] = '{KIND_VERDICT, 8'h00, 1'b0, 1'b0};
                     n = 3'd1;
                     if (gotany_ff) errcnt_in = errinc[7:0];
                     if (gotany_ff && errinc[7:0] >= err_limit) begin
                        r[1] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
                        r[2] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
                        n = 3'd3; sess_in = SS_ABORT;
                     end else begin
                        r[1] = '{KIND_REPLY, C_CRC, 1'b0, 1'b0};
                        n = 3'd2;
                     end
                  end else begin
                     errcnt_in = '0;
                     if (seq_ff != expseq_ff) begin
                        r[0] = '{KIND_VERDICT, 8'h00, 1'b0, 1'b0};
                        r[1] = '{KIND_REPLY, C_NAK, 1'b0, 1'b0};
                        n = 3'd2;
                     end else if (!gotany_ff) begin
                        r[0] = '{KIND_VERDICT, 8'h00, 1'b0, 1'b0};
                        r[1] = '{KIND_REPLY, C_ACK, 1'b0, 1'b0};
                        n = 3'd2;
                        if (headnz_ff) begin
                           size_in = accum_ff; remain_in = accum_ff;
                           r[2] = '{KIND_REPLY, C_CRC, 1'b0, 1'b0};
                           n = 3'd3;
                           gotany_in = 1'b1; expseq_in = expseq_ff + 8'd1;
                        end else begin
                           sess_in = SS_DONE;
                        end
                     end else begin
                        r[0] = '{KIND_VERDICT, 8'h00, 1'b0, 1'b1};
                        r[1] = '{KIND_REPLY, C_ACK, 1'b0, 1'b0};
                        n = 3'd2;
                        remain_in = remain_ff - dec;
                        expseq_in = expseq_ff + 8'd1;
                     end
                  end
               end
            end else if (frame_ff == FR_CANCEL) begin
               frame_in = FR_HEADER;
               r[0] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
               r[1] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
               n = 3'd2; sess_in = SS_ABORT;
            end else if (in_byte == C_SOH || in_byte == C_STX) begin
               frame_in = FR_BODY; idx_in = '0; long_in = (in_byte == C_STX);
               seq_in = '0; seqc_in = '0; crc_in = '0; headnz_in = 1'b0;
               parse_in = SP_NAME; digits_in = '0; accum_in = '0;
            end else if (in_byte == C_EOT) begin
               errcnt_in = '0; gotany_in = 1'b0; expseq_in = '0;
               r[0] = '{KIND_REPLY, C_ACK, 1'b0, 1'b0};
               r[1] = '{KIND_REPLY, C_CRC, 1'b0, 1'b0};
               n = 3'd2;
            end else if (in_byte == C_CAN) begin
               frame_in = FR_CANCEL;
            end else begin
               r[0] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
               r[1] = '{KIND_REPLY, C_CAN, 1'b0, 1'b0};
               n = 3'd2; sess_in = SS_ABORT;
            end
         end
      end
      bundle.count  = n;
      bundle.res    = r;
      bundle.size   = size_in;
      bundle.status = sess_in;
   end
endmodule
`default_nettype wire

// ===== sv/ymr_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ymr_outq import ymr_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  load,
   input  bundle_type bundle_in,
   output logic       empty,
   ymr_rsp_if.source  rsp
);
   bundle_type  buf_ff;
   logic [2:0]  pos_ff, pos_in;
   logic [2:0]  cnt_ff;
   logic [1:0]  sel;

   assign empty = (pos_ff == cnt_ff);
   assign sel = pos_ff[1:0];

   // Result bundle register; one result leaves per handshake.
   always_ff @(posedge clock) begin
      if (load) buf_ff <= bundle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cnt_ff <= '0;
      end else if (load) begin
         pos_ff <= '0;
         cnt_ff <= bundle_in.count;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (rsp.valid && rsp.ready) pos_in = pos_ff + 3'd1;
   end

   assign rsp.valid          = !empty;
   assign rsp.out_kind       = buf_ff.res[sel].kind;
   assign rsp.out_byte       = buf_ff.res[sel].data;
   assign rsp.keep_byte      = buf_ff.res[sel].keep;
   assign rsp.commit         = buf_ff.res[sel].commit;
   assign rsp.size_bytes     = buf_ff.size;
   assign rsp.session_status = buf_ff.status;
   assign rsp.last           = (pos_ff + 3'd1 == cnt_ff);
endmodule
`default_nettype wire
